// ===== hw/rtl/qft_pkg.sv =====
// ============================================================================
// qft_pkg: shared types and constants for the quoted field tokenizer
// Result kinds, phase codes, register map and the configuration bundle.
// ============================================================================
package qft_pkg;

    localparam int GROUP_PAIRS = 4;
    // Pair slots the opener/closer registers can hold
    localparam int SLOT_PAIRS  = 4;
    localparam int MAX_PAIRS   = (GROUP_PAIRS < SLOT_PAIRS) ? GROUP_PAIRS : SLOT_PAIRS;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        K_START    = 2'd0,
        K_CHAR     = 2'd1,
        K_END      = 2'd2,
        K_LIST_END = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PLAIN = 3'b010,
        PH_GROUP = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        REG_DELIMITER  = 2'd0,
        REG_OPENERS    = 2'd1,
        REG_CLOSERS    = 2'd2,
        REG_PAIRS_USED = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  delimiter;
        logic [31:0] openers;
        logic [31:0] closers;
        logic [2:0]  pairs_used;
    } t_cfg;

    typedef struct packed {
        logic       last;
        t_kind      kind;
        logic [7:0] chr;
    } t_result;

    // Outcome of decoding one byte
    typedef struct packed {
        logic [1:0] n_res;
        t_result    res0;
        t_result    res1;
        t_phase     phase;
        logic [7:0] closer;
    } t_dec;

endpackage

// ===== hw/rtl/quoted_field_tokenizer_top.sv =====
// ============================================================================
// quoted_field_tokenizer_top: byte-stream tokenizer with quote pairs
// Splits a zero-terminated byte stream into start/char/end/list-end marks.
// ============================================================================
// Path: an accepted byte is held in the input register, then decoded into
//   the result queue, whose head offers its first result.
// Throughput: one byte per cycle; decode waits while three or more results
//   are queued, so two-result bytes in a row cannot all pass at that rate.
// Reset (i_rst_n low, synchronous): registers to defaults (delimiter 32,
//   grouping off), phase idle, input register and result queue emptied.
module quoted_field_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    qft_pkg::t_cfg     w_cfg;
    qft_pkg::t_dec     w_dec;
    qft_pkg::t_result  w_head;
    logic [qft_pkg::FIFO_CW-1:0] w_count;

    // Input register
    logic              r_in_vld;
    logic [7:0]        r_in_char;
    // Tokenizer state
    qft_pkg::t_phase   r_phase;
    logic [7:0]        r_closer;

    logic              w_accept;
    logic              w_fire;
    logic [1:0]        w_push_n;

    qft_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Decode fires only when the queue can swallow a worst-case two results
    assign w_fire   = r_in_vld &&
                      (w_count <= qft_pkg::FIFO_CW'(qft_pkg::FIFO_DEPTH - 2));
    assign s_tready = !r_in_vld || w_fire;
    assign w_accept = s_tvalid & s_tready;
    assign w_push_n = w_fire ? w_dec.n_res : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept || (r_in_vld && !w_fire);
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) r_in_char <= s_tdata;
    end

    qft_decode u_decode (
        .i_phase  (r_phase),
        .i_closer (r_closer),
        .i_char   (r_in_char),
        .i_cfg    (w_cfg),
        .o_dec    (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= qft_pkg::PH_IDLE;
            r_closer <= '0;
        end else if (w_fire) begin
            r_phase  <= w_dec.phase;
            r_closer <= w_dec.closer;
        end
    end

    qft_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_dec.res0),
        .i_res1   (w_dec.res1),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_res    (w_head),
        .o_count  (w_count)
    );

    assign m_tdata = w_head.chr;
    assign m_tuser = w_head.kind;
    assign m_tlast = w_head.last;

    // ---------------------------------------------------------------- checks
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= qft_pkg::FIFO_CW'(qft_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> r_in_vld)
        else $error("input stalled with empty input register");

    a_eos_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_char == 8'd0) |=> (r_phase == qft_pkg::PH_IDLE))
        else $error("phase not idle after end of string");

    a_list_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == qft_pkg::K_LIST_END) |-> m_tlast)
        else $error("list end without last");

endmodule

// ===== hw/rtl/qft_cfg.sv =====
// ============================================================================
// qft_cfg: configuration register file
// APB-style write/read of delimiter, opener, closer and pair-count registers.
// ============================================================================
module qft_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output qft_pkg::t_cfg     o_cfg
);

    qft_pkg::t_cfg   r_cfg;
    qft_pkg::t_reg_idx w_idx;
    logic            w_wr;

    assign pready = 1'b1;
    assign w_idx  = qft_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter  <= 8'd32;
            r_cfg.openers    <= '0;
            r_cfg.closers    <= '0;
            r_cfg.pairs_used <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                qft_pkg::REG_DELIMITER:  r_cfg.delimiter  <= pwdata[7:0];
                qft_pkg::REG_OPENERS:    r_cfg.openers    <= pwdata;
                qft_pkg::REG_CLOSERS:    r_cfg.closers    <= pwdata;
                qft_pkg::REG_PAIRS_USED: r_cfg.pairs_used <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            qft_pkg::REG_DELIMITER:  prdata = {24'd0, r_cfg.delimiter};
            qft_pkg::REG_OPENERS:    prdata = r_cfg.openers;
            qft_pkg::REG_CLOSERS:    prdata = r_cfg.closers;
            qft_pkg::REG_PAIRS_USED: prdata = {29'd0, r_cfg.pairs_used};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/qft_decode.sv =====
// ============================================================================
// qft_decode: per-byte tokenizer decision
// Given the phase and one byte, produces up to two results and the next state.
// ============================================================================
module qft_decode (
    input  qft_pkg::t_phase   i_phase,
    input  logic [7:0]        i_closer,
    input  logic [7:0]        i_char,
    input  qft_pkg::t_cfg     i_cfg,
    output qft_pkg::t_dec     o_dec
);

    logic       w_open;
    logic [7:0] w_open_closer;
    logic [2:0] w_npairs;

    // Pair walk: opener k, closer k, ...; stops at a zero slot or a byte match
    always_comb begin
        logic       done;
        logic [7:0] o_b;
        logic [7:0] c_b;
        done          = 1'b0;
        w_open        = 1'b0;
        w_open_closer = '0;
        w_npairs      = (i_cfg.pairs_used > 3'(qft_pkg::MAX_PAIRS)) ?
                        3'(qft_pkg::MAX_PAIRS) : i_cfg.pairs_used;
        for (int k = 0; k < qft_pkg::MAX_PAIRS; k++) begin
            o_b = i_cfg.openers[8*k +: 8];
            c_b = i_cfg.closers[8*k +: 8];
            if (!done && (3'(k) < w_npairs)) begin
                if (o_b == 8'd0) begin
                    done = 1'b1;
                end else if (o_b == i_char) begin
                    done          = 1'b1;
                    w_open        = 1'b1;
                    w_open_closer = c_b;
                end else if (c_b == 8'd0 || c_b == i_char) begin
                    done = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_dec        = '0;
        o_dec.phase  = i_phase;
        o_dec.closer = i_closer;
        o_dec.res0.kind = qft_pkg::K_START;
        o_dec.res1.kind = qft_pkg::K_START;
        unique case (i_phase) inside
            qft_pkg::PH_PLAIN, qft_pkg::PH_GROUP: begin
                if (i_char == 8'd0) begin
                    o_dec.n_res     = 2'd2;
                    o_dec.res0.kind = qft_pkg::K_END;
                    o_dec.res1.kind = qft_pkg::K_LIST_END;
                    o_dec.res1.last = 1'b1;
                    o_dec.phase     = qft_pkg::PH_IDLE;
                    o_dec.closer    = '0;
                end else if ((i_phase == qft_pkg::PH_PLAIN && i_char == i_cfg.delimiter) ||
                             (i_phase == qft_pkg::PH_GROUP && i_char == i_closer)) begin
                    o_dec.n_res     = 2'd1;
                    o_dec.res0.kind = qft_pkg::K_END;
                    o_dec.res0.last = 1'b1;
                    o_dec.phase     = qft_pkg::PH_IDLE;
                    o_dec.closer    = '0;
                end else begin
                    o_dec.n_res     = 2'd1;
                    o_dec.res0.kind = qft_pkg::K_CHAR;
                    o_dec.res0.chr  = i_char;
                    o_dec.res0.last = 1'b1;
                end
            end
            default: begin
                o_dec.phase = qft_pkg::PH_IDLE;
                if (i_char == 8'd0) begin
                    o_dec.n_res     = 2'd1;
                    o_dec.res0.kind = qft_pkg::K_LIST_END;
                    o_dec.res0.last = 1'b1;
                end else if (i_char == i_cfg.delimiter) begin
                    o_dec.n_res = 2'd0;
                end else if (w_open) begin
                    o_dec.n_res     = 2'd1;
                    o_dec.res0.kind = qft_pkg::K_START;
                    o_dec.res0.last = 1'b1;
                    o_dec.phase     = qft_pkg::PH_GROUP;
                    o_dec.closer    = w_open_closer;
                end else begin
                    o_dec.n_res     = 2'd2;
                    o_dec.res0.kind = qft_pkg::K_START;
                    o_dec.res1.kind = qft_pkg::K_CHAR;
                    o_dec.res1.chr  = i_char;
                    o_dec.res1.last = 1'b1;
                    o_dec.phase     = qft_pkg::PH_PLAIN;
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/qft_res_fifo.sv =====
// ============================================================================
// qft_res_fifo: small result queue
// Takes up to two results per cycle, hands out one per transfer.
// ============================================================================
module qft_res_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_n,
    input  qft_pkg::t_result             i_res0,
    input  qft_pkg::t_result             i_res1,
    output logic                         o_valid,
    input  logic                         i_ready,
    output qft_pkg::t_result             o_res,
    output logic [qft_pkg::FIFO_CW-1:0]  o_count
);

    qft_pkg::t_result                r_mem [qft_pkg::FIFO_DEPTH];
    logic [qft_pkg::FIFO_AW-1:0]     r_wr_ptr;
    logic [qft_pkg::FIFO_AW-1:0]     r_rd_ptr;
    logic [qft_pkg::FIFO_CW-1:0]     r_count;
    logic                            w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid & i_ready;
    assign o_res   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + qft_pkg::FIFO_AW'(i_push_n);
            r_rd_ptr <= r_rd_ptr + qft_pkg::FIFO_AW'(w_pop);
            r_count  <= r_count + qft_pkg::FIFO_CW'(i_push_n)
                        - qft_pkg::FIFO_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wr_ptr] <= i_res0;
        if (i_push_n == 2'd2) r_mem[r_wr_ptr + qft_pkg::FIFO_AW'(1)] <= i_res1;
    end

endmodule
